### rtl/tcw_pkg.sv
// shared types and constants for the text console writer
// no dependencies
package tcw_pkg;

  localparam int DEFAULT_COLUMNS = 80;
  localparam int DEFAULT_ROWS = 25;
  localparam int DEFAULT_QUEUE_DEPTH = 2;

  localparam int OFFSET_W = 11;
  localparam int INDEX_W = 11;

  localparam logic [15:0] BLANK_CELL = 16'h0700;
  localparam logic [7:0] RESET_COLOR = 8'h07;
  localparam logic [7:0] NUL_CODE = 8'h00;
  localparam logic [7:0] NEWLINE_CODE = 8'h0a;

  localparam logic [2:0] OP_COOKED = 3'd0;
  localparam logic [2:0] OP_RAW = 3'd1;
  localparam logic [2:0] OP_SET_COLOR = 3'd2;
  localparam logic [2:0] OP_CLEAR = 3'd3;
  localparam logic [2:0] OP_READ = 3'd4;

  typedef enum logic [2:0] {
    K_NOP     = 3'd0,
    K_WRITE   = 3'd1,
    K_NEWLINE = 3'd2,
    K_CLEAR   = 3'd3,
    K_READ    = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [15:0]         data;
    logic [INDEX_W-1:0]  addr;
    logic                in_range;
  } cmd_t;

endpackage

### rtl/tcw_front.sv
// front end: accepts input words, keeps the current color, classifies into commands
// depends on tcw_pkg
module tcw_front #(
  parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
  parameter int ROWS = tcw_pkg::DEFAULT_ROWS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  opcode,
  input  logic [7:0]                  char_code,
  input  logic [7:0]                  color,
  input  logic [tcw_pkg::INDEX_W-1:0] cell_index,
  input  logic                        q_ready,
  input  logic                        init_done,
  output logic                        q_push,
  output tcw_pkg::cmd_t               q_cmd
);

  localparam int CELLS = COLUMNS * ROWS;

  logic [7:0] current_color;

  assign in_ready = q_ready && init_done;
  assign q_push = in_valid && in_ready;

  always_comb begin
    q_cmd.kind = tcw_pkg::K_NOP;
    q_cmd.data = {current_color, char_code};
    q_cmd.addr = cell_index;
    q_cmd.in_range = (int'(cell_index) < CELLS);
    case (opcode)
      tcw_pkg::OP_COOKED: begin
        if (char_code == tcw_pkg::NEWLINE_CODE) begin
          q_cmd.kind = tcw_pkg::K_NEWLINE;
        end else if (char_code != tcw_pkg::NUL_CODE) begin
          q_cmd.kind = tcw_pkg::K_WRITE;
        end
      end
      tcw_pkg::OP_RAW: begin
        q_cmd.kind = tcw_pkg::K_WRITE;
        q_cmd.data = {color, char_code};
      end
      tcw_pkg::OP_CLEAR: q_cmd.kind = tcw_pkg::K_CLEAR;
      tcw_pkg::OP_READ: q_cmd.kind = tcw_pkg::K_READ;
      default: q_cmd.kind = tcw_pkg::K_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_color <= tcw_pkg::RESET_COLOR;
    end else if (q_push && opcode == tcw_pkg::OP_SET_COLOR) begin
      current_color <= color;
    end
  end

endmodule

### rtl/tcw_queue.sv
// short command queue between front end and back end
// depends on tcw_pkg
module tcw_queue #(
  parameter int DEPTH = tcw_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tcw_pkg::cmd_t push_cmd,
  output logic          push_ready,
  output logic          pop_valid,
  output tcw_pkg::cmd_t pop_cmd,
  input  logic          pop
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  tcw_pkg::cmd_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;

  assign push_ready = (count != NW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> push_ready)
    else $error("word pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> pop_valid)
    else $error("word popped from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow push");

endmodule

### rtl/tcw_back.sv
// back end: cell store, cursor, scroll and clear sweeps, result register
// depends on tcw_pkg
module tcw_back #(
  parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
  parameter int ROWS = tcw_pkg::DEFAULT_ROWS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  tcw_pkg::cmd_t                q_cmd,
  output logic                         q_pop,
  output logic                         init_done,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tcw_pkg::OFFSET_W-1:0] cursor_offset,
  output logic [15:0]                  cell_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW = $clog2(CELLS);
  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam int OW = (AW > tcw_pkg::OFFSET_W) ? AW : tcw_pkg::OFFSET_W;
  localparam logic [AW-1:0] MOVE_END = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] ROW_STEP = AW'(COLUMNS);
  localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_READ   = 6'b000100,
    S_SCROLL = 6'b001000,
    S_FILL   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state;

  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata;
  logic [AW-1:0] ptr;
  logic [AW-1:0] pos;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          wr_pending;
  logic [AW-1:0] wr_addr;
  logic [15:0]   res_data;
  logic [OW-1:0] pos_wide;

  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic          re;
  logic [AW-1:0] raddr;

  assign init_done = (state != S_INIT);
  assign q_pop = (state == S_IDLE) && q_valid;
  assign pos_wide = OW'(pos);

  always_comb begin
    we = 1'b0;
    waddr = ptr;
    wdata = tcw_pkg::BLANK_CELL;
    re = 1'b0;
    raddr = ptr + ROW_STEP;
    case (state)
      S_INIT, S_FILL: we = 1'b1;
      S_IDLE: begin
        if (q_valid && q_cmd.kind == tcw_pkg::K_WRITE) begin
          we = 1'b1;
          waddr = pos;
          wdata = q_cmd.data;
        end else if (q_valid && q_cmd.kind == tcw_pkg::K_READ) begin
          re = q_cmd.in_range;
          raddr = AW'(q_cmd.addr);
        end
      end
      S_SCROLL: begin
        re = (ptr != MOVE_END);
        we = wr_pending;
        waddr = wr_addr;
        wdata = rdata;
      end
      default: ;
    endcase
  end

  // cell store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      ptr <= '0;
      pos <= '0;
      col <= '0;
      row <= '0;
      wr_pending <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      wr_pending <= 1'b0;
      case (state)
        S_INIT: begin
          ptr <= ptr + 1'b1;
          if (ptr == LAST_CELL) begin
            state <= S_IDLE;
          end
        end
        S_FILL: begin
          ptr <= ptr + 1'b1;
          if (ptr == LAST_CELL) begin
            state <= S_DONE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            res_data <= '0;
            state <= S_DONE;
            case (q_cmd.kind)
              tcw_pkg::K_WRITE: begin
                if (col == LAST_COL) begin
                  col <= '0;
                  if (row == LAST_ROW) begin
                    pos <= MOVE_END;
                    ptr <= '0;
                    state <= S_SCROLL;
                  end else begin
                    row <= row + 1'b1;
                    pos <= pos + 1'b1;
                  end
                end else begin
                  col <= col + 1'b1;
                  pos <= pos + 1'b1;
                end
              end
              tcw_pkg::K_NEWLINE: begin
                col <= '0;
                if (row == LAST_ROW) begin
                  pos <= MOVE_END;
                  ptr <= '0;
                  state <= S_SCROLL;
                end else begin
                  row <= row + 1'b1;
                  pos <= pos - AW'(col) + ROW_STEP;
                end
              end
              tcw_pkg::K_CLEAR: begin
                ptr <= '0;
                state <= S_FILL;
              end
              tcw_pkg::K_READ: begin
                if (q_cmd.in_range) begin
                  state <= S_READ;
                end
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          res_data <= rdata;
          state <= S_DONE;
        end
        S_SCROLL: begin
          // read one row below, write it back in the next cycle
          wr_pending <= re;
          wr_addr <= ptr;
          if (ptr == MOVE_END) begin
            state <= S_FILL;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            cursor_offset <= pos_wide[tcw_pkg::OFFSET_W-1:0];
            cell_data <= res_data;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cursor_map: assert property (@(posedge clk) disable iff (rst)
    pos == AW'(int'(row) * COLUMNS + int'(col)))
    else $error("linear cursor out of step with row and column");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    int'(col) < COLUMNS && int'(row) < ROWS)
    else $error("cursor outside the screen");

  a_read_after_pop: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> $past(q_pop))
    else $error("cell read without a popped command");

  a_no_pop_in_init: assert property (@(posedge clk) disable iff (rst)
    !init_done |-> !q_pop)
    else $error("command taken during the clearing pass");

endmodule

### rtl/text_console_writer.sv
// text console writer top level: front end, command queue, back end
// depends on tcw_pkg, tcw_front, tcw_queue, tcw_back
//
// input channel in_valid/in_ready carries one word: opcode, char_code, color,
// cell_index. output channel out_valid/out_ready returns exactly one word per
// input word, in order: cursor_offset after the step, and cell_data (the cell
// for a read, zero otherwise).
// path: a put, color change, nop or out-of-range read goes from the queue
// through the back end's done state into the output register; an in-range
// read also passes its read state. a clear first walks the whole store. a
// wrap past the last row scrolls: one pass over the store through its single
// write port. the back end pops a word and delivers its result before it
// pops the next; the queue keeps accepting while the back end works.
// reset: clears the cursor, sets the color to light gray and then sweeps
// every cell to blank; in_ready stays low during the sweep.
// when the receiver stalls, the finished word holds in the output register,
// the back end waits and the queue fills before in_ready drops.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
  parameter int ROWS = tcw_pkg::DEFAULT_ROWS,
  parameter int QUEUE_DEPTH = tcw_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   opcode,
  input  logic [7:0]                   char_code,
  input  logic [7:0]                   color,
  input  logic [tcw_pkg::INDEX_W-1:0]  cell_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tcw_pkg::OFFSET_W-1:0] cursor_offset,
  output logic [15:0]                  cell_data
);

  tcw_pkg::cmd_t push_cmd;
  tcw_pkg::cmd_t pop_cmd;
  logic          push;
  logic          push_ready;
  logic          pop_valid;
  logic          pop;
  logic          init_done;

  tcw_front #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .char_code(char_code),
    .color(color),
    .cell_index(cell_index),
    .q_ready(push_ready),
    .init_done(init_done),
    .q_push(push),
    .q_cmd(push_cmd)
  );

  tcw_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_cmd(push_cmd),
    .push_ready(push_ready),
    .pop_valid(pop_valid),
    .pop_cmd(pop_cmd),
    .pop(pop)
  );

  tcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(pop_valid),
    .q_cmd(pop_cmd),
    .q_pop(pop),
    .init_done(init_done),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cursor_offset(cursor_offset),
    .cell_data(cell_data)
  );

endmodule
